[hw/rtl/easing_curve_interpolator_macros.svh]
`ifndef EASING_CURVE_INTERPOLATOR_MACROS_SVH
`define EASING_CURVE_INTERPOLATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define ECI_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define ECI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/eci_pkg.sv]
package eci_pkg;

  typedef enum logic [2:0] {
    CMD_LIN  = 3'd0,
    CMD_SQR  = 3'd1,
    CMD_CUB  = 3'd2,
    CMD_QRT  = 3'd3,
    CMD_RSQR = 3'd4,
    CMD_RCUB = 3'd5
  } cmd_e;

  localparam logic [31:0] INT32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT32_MIN = 32'h8000_0000;

  // quotients above 2**SAT_BIT saturate at once
  localparam int unsigned SAT_BIT = 40;

endpackage

[hw/rtl/easing_curve_interpolator.sv]
// path: an item passes the front stages, the divider stages and the result stage into the output register
// throughput: one item per cycle while the skid slot is empty; the divider retires one quotient bit per stage
// a stalled output parks one result in a skid register while the pipeline holds
// reset: asynchronous, active low; clears all valid bits, payload registers keep their contents
`include "easing_curve_interpolator_macros.svh"

module easing_curve_interpolator
  import eci_pkg::*;
#(
  parameter int unsigned POS_WIDTH   = 10,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // start_value, end_value, position, span, zero pad
  input  logic [((2*VALUE_WIDTH+2*POS_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // cmd
  input  logic [2:0] s_axis_tuser_i,

  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // value
  output logic [31:0] m_axis_tdata_o,
  // saturated
  output logic [0:0] m_axis_tuser_o
);

  localparam int unsigned P  = POS_WIDTH;
  localparam int unsigned V  = VALUE_WIDTH;
  localparam int unsigned DW = V + 1;
  localparam int unsigned HW = 2 * P;
  localparam int unsigned MW = 4 * P;
  localparam int unsigned NW = MW + DW;
  localparam int unsigned PW = HW + DW;
  localparam int unsigned QW = (NW > SAT_BIT + 2) ? NW : SAT_BIT + 2;
  localparam int unsigned SW = SAT_BIT + 3;

  typedef struct packed {
    logic         bypass;
    logic         up;
    logic [V-1:0] base;
  } ctl_t;

  logic en;

  // decode
  logic [V-1:0]  in_lo, in_hi;
  logic [P-1:0]  in_x, in_s, in_m;
  logic [DW-1:0] in_diff, in_dmag;
  logic          in_neg, in_rev, in_past, in_flip, in_inval, in_zero;
  logic [1:0]    in_k;
  ctl_t          in_ctl;

  always_comb begin
    in_lo   = s_axis_tdata_i[V-1:0];
    in_hi   = s_axis_tdata_i[2*V-1:V];
    in_x    = s_axis_tdata_i[2*V+P-1:2*V];
    in_s    = s_axis_tdata_i[2*V+2*P-1:2*V+P];
    in_diff = {in_hi[V-1], in_hi} - {in_lo[V-1], in_lo};
    in_neg  = in_diff[DW-1];
    in_dmag = in_neg ? (~in_diff + DW'(1)) : in_diff;
    in_past = in_x > in_s;
    in_rev  = 1'b0;
    in_flip = 1'b0;
    in_k    = 2'd0;
    unique case (cmd_e'(s_axis_tuser_i))
      CMD_LIN:  in_k = 2'd0;
      CMD_SQR:  in_k = 2'd1;
      CMD_CUB:  in_k = 2'd2;
      CMD_QRT:  in_k = 2'd3;
      CMD_RSQR: begin
        in_k   = 2'd1;
        in_rev = 1'b1;
      end
      CMD_RCUB: begin
        in_k    = 2'd2;
        in_rev  = 1'b1;
        in_flip = in_past;
      end
      default:  in_k = 2'd0;
    endcase
    in_inval = s_axis_tuser_i > CMD_RCUB;
    in_zero  = in_s == '0;
    in_m     = in_rev ? (in_past ? in_x - in_s : in_s - in_x) : in_x;
    in_ctl.bypass = in_zero || in_inval;
    in_ctl.up     = in_rev ? (in_neg ^ in_flip) : !in_neg;
    if (in_zero) begin
      in_ctl.base = in_hi;
    end else if (in_inval) begin
      in_ctl.base = '0;
    end else begin
      in_ctl.base = in_rev ? in_hi : in_lo;
    end
  end

  // stage 1: decoded item
  logic          v1_q;
  ctl_t          c1_q;
  logic [1:0]    k1_q;
  logic [P-1:0]  m1_q, s1_q;
  logic [DW-1:0] d1_q;

  // stage 2: squares
  logic          v2_q;
  ctl_t          c2_q;
  logic [1:0]    k2_q;
  logic [P-1:0]  m2a_q, s2a_q;
  logic [HW-1:0] m2b_q, s2b_q;
  logic [DW-1:0] d2_q;

  // stage 3: selected powers
  logic          v3_q;
  ctl_t          c3_q;
  logic [MW-1:0] pw3_q, dv3_q;
  logic [DW-1:0] d3_q;

  // stage 4: partial products
  logic          v4_q;
  ctl_t          c4_q;
  logic [PW-1:0] pl4_q, ph4_q;
  logic [MW-1:0] dv4_q;

  // stage 5: numerator
  logic          v5_q;
  ctl_t          c5_q;
  logic [NW-1:0] num5_q;
  logic [MW-1:0] dv5_q;

  logic [3*P-1:0] m3_w, s3_w;
  logic [MW-1:0]  m4_w, s4_w, pw_w, dv_w;

  always_comb begin
    m3_w = (3*P)'(m2b_q) * (3*P)'(m2a_q);
    s3_w = (3*P)'(s2b_q) * (3*P)'(s2a_q);
    m4_w = MW'(m2b_q) * MW'(m2b_q);
    s4_w = MW'(s2b_q) * MW'(s2b_q);
    unique case (k2_q)
      2'd0: begin
        pw_w = MW'(m2a_q);
        dv_w = MW'(s2a_q);
      end
      2'd1: begin
        pw_w = MW'(m2b_q);
        dv_w = MW'(s2b_q);
      end
      2'd2: begin
        pw_w = MW'(m3_w);
        dv_w = MW'(s3_w);
      end
      default: begin
        pw_w = m4_w;
        dv_w = s4_w;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q   <= in_ctl;
      k1_q   <= in_k;
      m1_q   <= in_m;
      s1_q   <= in_s;
      d1_q   <= in_dmag;

      c2_q   <= c1_q;
      k2_q   <= k1_q;
      m2a_q  <= m1_q;
      s2a_q  <= s1_q;
      m2b_q  <= HW'(m1_q) * HW'(m1_q);
      s2b_q  <= HW'(s1_q) * HW'(s1_q);
      d2_q   <= d1_q;

      c3_q   <= c2_q;
      pw3_q  <= pw_w;
      dv3_q  <= dv_w;
      d3_q   <= d2_q;

      c4_q   <= c3_q;
      pl4_q  <= PW'(pw3_q[HW-1:0]) * PW'(d3_q);
      ph4_q  <= PW'(pw3_q[MW-1:HW]) * PW'(d3_q);
      dv4_q  <= dv3_q;

      c5_q   <= c4_q;
      num5_q <= NW'(pl4_q) + (NW'(ph4_q) << HW);
      dv5_q  <= dv4_q;
    end
  end

  // restoring divider, one quotient bit per stage
  logic          dv_q   [NW];
  ctl_t          dc_q   [NW];
  logic [MW-1:0] drem_q [NW];
  logic [MW-1:0] dden_q [NW];
  logic [NW-1:0] dnq_q  [NW];

  for (genvar j = 0; j < NW; j++) begin : g_div
    logic          v_i;
    ctl_t          c_i;
    logic [MW-1:0] rem_i, den_i;
    logic [NW-1:0] nq_i;
    logic [MW:0]   t_w, sub_w;
    logic          ge_w;

    if (j == 0) begin : g_first
      assign v_i   = v5_q;
      assign c_i   = c5_q;
      assign rem_i = '0;
      assign den_i = dv5_q;
      assign nq_i  = num5_q;
    end else begin : g_next
      assign v_i   = dv_q[j-1];
      assign c_i   = dc_q[j-1];
      assign rem_i = drem_q[j-1];
      assign den_i = dden_q[j-1];
      assign nq_i  = dnq_q[j-1];
    end

    always_comb begin
      t_w   = {rem_i, nq_i[NW-1]};
      sub_w = t_w - {1'b0, den_i};
      ge_w  = t_w >= {1'b0, den_i};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en) begin
        dv_q[j] <= v_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dc_q[j]   <= c_i;
        dden_q[j] <= den_i;
        drem_q[j] <= ge_w ? sub_w[MW-1:0] : t_w[MW-1:0];
        dnq_q[j]  <= {nq_i[NW-2:0], ge_w};
      end
    end
  end

  // result stage: range check and signed add
  logic [QW-1:0] q_w;
  logic [SW-1:0] base_w, qe_w;
  logic          vr_q, big_q;
  ctl_t          cr_q;
  logic [SW-1:0] sum_q;

  always_comb begin
    q_w    = QW'(dnq_q[NW-1]);
    base_w = {{(SW-V){dc_q[NW-1].base[V-1]}}, dc_q[NW-1].base};
    qe_w   = {{(SW-SAT_BIT-1){1'b0}}, q_w[SAT_BIT:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (en) begin
      vr_q <= dv_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_q  <= dc_q[NW-1];
      big_q <= q_w > (QW'(1) << SAT_BIT);
      sum_q <= dc_q[NW-1].up ? base_w + qe_w : base_w - qe_w;
    end
  end

  // bypass and saturation
  logic [31:0] fin_value;
  logic        fin_sat;

  always_comb begin
    fin_value = sum_q[31:0];
    fin_sat   = 1'b0;
    priority if (cr_q.bypass) begin
      fin_value = {{(32-V){cr_q.base[V-1]}}, cr_q.base};
    end else if (big_q) begin
      fin_value = cr_q.up ? INT32_MAX : INT32_MIN;
      fin_sat   = 1'b1;
    end else if (!sum_q[SW-1] && (|sum_q[SW-2:31])) begin
      fin_value = INT32_MAX;
      fin_sat   = 1'b1;
    end else if (sum_q[SW-1] && !(&sum_q[SW-2:31])) begin
      fin_value = INT32_MIN;
      fin_sat   = 1'b1;
    end else begin
      fin_value = sum_q[31:0];
    end
  end

  // output register with skid slot
  logic        out_vld_q, skd_vld_q;
  logic [31:0] out_val_q, skd_val_q;
  logic        out_sat_q, skd_sat_q;
  logic        fin_v;

  assign en    = !skd_vld_q;
  assign fin_v = vr_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else if (m_axis_tready_i || !out_vld_q) begin
      out_vld_q <= skd_vld_q || fin_v;
      skd_vld_q <= 1'b0;
    end else if (fin_v) begin
      skd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_axis_tready_i || !out_vld_q) begin
      if (skd_vld_q) begin
        out_val_q <= skd_val_q;
        out_sat_q <= skd_sat_q;
      end else begin
        out_val_q <= fin_value;
        out_sat_q <= fin_sat;
      end
    end else if (fin_v) begin
      skd_val_q <= fin_value;
      skd_sat_q <= fin_sat;
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = out_sat_q;

  `ECI_ASSERT_IMPL(a_skid_behind_out, skd_vld_q, out_vld_q, "skid slot filled while output empty")
  `ECI_ASSERT_NEXT(a_stall_holds, !en, $stable({v1_q, v5_q, vr_q, sum_q}), "pipeline moved during stall")
  `ECI_ASSERT_IMPL(a_sat_rails, m_axis_tvalid_o && m_axis_tuser_o[0], (m_axis_tdata_o == INT32_MAX) || (m_axis_tdata_o == INT32_MIN), "saturated result off the rails")

endmodule

[dv/testbench.sv]
module testbench;
  import eci_pkg::*;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned TDATA_W = ((2*VAL_W+2*POS_W+7)/8)*8;

  localparam logic [2:0] CMD_BAD_LO = 3'd6;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_ITEMS   = 200;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_ITEMS   = 150;
  localparam int DRAIN_AT     = 800;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 100;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [31:0] value;
    logic        saturated;
  } curve_result_t;

  class curve_scoreboard;
    curve_result_t expected_results[$];
    int errors = 0;

    function curve_result_t eased_value(logic [2:0] cmd,
                                        logic signed [VAL_W-1:0] lo,
                                        logic signed [VAL_W-1:0] hi,
                                        logic [POS_W-1:0] x,
                                        logic [POS_W-1:0] s);
      longint signed   diff, base, sum;
      longint unsigned mag, step, num, den, quo;
      int unsigned     k;
      bit              neg, rev, up;
      curve_result_t   res;
      res = '0;
      case (cmd)
        CMD_LIN: begin
          k = 1;
        end
        CMD_SQR, CMD_RSQR: begin
          k = 2;
        end
        CMD_CUB, CMD_RCUB: begin
          k = 3;
        end
        CMD_QRT: begin
          k = 4;
        end
        default: begin
          k = 0;
        end
      endcase
      rev = (cmd == CMD_RSQR) || (cmd == CMD_RCUB);
      if (s == '0) begin
        res.value = 32'(longint'(hi));
      end else if (k != 0) begin
        diff = longint'(hi) - longint'(lo);
        neg  = diff < 0;
        mag  = neg ? -diff : diff;
        if (rev) begin
          // past the span the distance goes negative, odd powers flip sign
          if (x > s) begin
            step = x - s;
            if (k == 3) begin
              neg = !neg;
            end
          end else begin
            step = s - x;
          end
          base = hi;
        end else begin
          step = x;
          base = lo;
        end
        num = mag;
        den = 1;
        for (int i = 0; i < k; i++) begin
          num = num * step;
          den = den * s;
        end
        quo = num / den;
        up  = rev ? neg : !neg;
        if (quo > (64'd1 << SAT_BIT)) begin
          res.value     = up ? INT32_MAX : INT32_MIN;
          res.saturated = 1'b1;
        end else begin
          sum = up ? base + longint'(quo) : base - longint'(quo);
          if (sum > longint'(INT32_MAX)) begin
            res.value     = INT32_MAX;
            res.saturated = 1'b1;
          end else if (sum < longint'($signed(INT32_MIN))) begin
            res.value     = INT32_MIN;
            res.saturated = 1'b1;
          end else begin
            res.value = 32'(sum);
          end
        end
      end
      return res;
    endfunction

    function void note(logic [2:0] cmd, logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi,
                       logic [POS_W-1:0] x, logic [POS_W-1:0] s);
      expected_results.push_back(eased_value(cmd, lo, hi, x, s));
    endfunction

    function void check(logic [31:0] value, logic saturated);
      curve_result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %h saturated %b", value, saturated);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (value !== exp_r.value) begin
        $error("value: expected %h, got %h", exp_r.value, value);
        errors++;
      end
      if (saturated !== exp_r.saturated) begin
        $error("saturated: expected %b, got %b", exp_r.saturated, saturated);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata  = '0;
  logic [2:0]         s_tuser  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [31:0]        m_tdata;
  logic [0:0]         m_tuser;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  curve_scoreboard sb = new();

  easing_curve_interpolator #(
    .POS_WIDTH  (POS_W),
    .VALUE_WIDTH(VAL_W)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int sender_gap();
    if (calm || $urandom_range(0, 3) != 0) begin
      return 0;
    end
    return $urandom_range(1, 10);
  endfunction

  task automatic send_curve(logic [2:0] cmd, logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi,
                            logic [POS_W-1:0] x, logic [POS_W-1:0] s, int gap);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= TDATA_W'({s, x, hi, lo});
    do @(posedge clk_i); while (!s_tready);
    sb.note(cmd, lo, hi, x, s);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : receiver
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        // long hold so the pipeline fills and stalls the input
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      sb.check(m_tdata, m_tuser[0]);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    logic [2:0]       cmd;
    logic [VAL_W-1:0] lo, hi;
    logic [POS_W-1:0] x, s;
    int               gap;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero span, invalid curves, extremes and overshoot
    send_curve(CMD_LIN,    16'h8000, 16'h7fff, 10'd5,    10'd0,    sender_gap());
    send_curve(CMD_BAD_HI, 16'h1234, 16'h8000, 10'd1023, 10'd0,    sender_gap());
    send_curve(CMD_BAD_LO, 16'h8000, 16'h7fff, 10'd3,    10'd10,   sender_gap());
    send_curve(CMD_BAD_HI, 16'h7fff, 16'h8000, 10'd1023, 10'd1023, sender_gap());
    send_curve(CMD_LIN,    16'h8000, 16'h7fff, 10'd0,    10'd1023, sender_gap());
    send_curve(CMD_LIN,    16'h8000, 16'h7fff, 10'd1023, 10'd1023, sender_gap());
    send_curve(CMD_LIN,    16'h8000, 16'h7fff, 10'd1023, 10'd1,    sender_gap());
    send_curve(CMD_SQR,    16'h7fff, 16'h8000, 10'd512,  10'd1023, sender_gap());
    send_curve(CMD_CUB,    16'h8000, 16'h7fff, 10'd1023, 10'd1,    sender_gap());
    send_curve(CMD_QRT,    16'h7fff, 16'h8000, 10'd1023, 10'd1,    sender_gap());
    send_curve(CMD_QRT,    16'h0010, 16'h1000, 10'd300,  10'd1000, sender_gap());
    send_curve(CMD_RSQR,   16'h8000, 16'h7fff, 10'd0,    10'd1023, sender_gap());
    send_curve(CMD_RSQR,   16'h8000, 16'h7fff, 10'd1023, 10'd1,    sender_gap());
    send_curve(CMD_RCUB,   16'h8000, 16'h7fff, 10'd1023, 10'd1,    sender_gap());
    send_curve(CMD_RCUB,   16'h7fff, 16'h8000, 10'd100,  10'd1023, sender_gap());
    send_curve(CMD_RCUB,   16'h0064, 16'hff9c, 10'd1023, 10'd1000, sender_gap());
    send_curve(CMD_LIN,    16'h0000, 16'h0000, 10'd7,    10'd3,    sender_gap());
    send_curve(CMD_LIN,    16'h0000, 16'hfff9, 10'd1,    10'd2,    sender_gap());
    send_curve(CMD_SQR,    16'h8000, 16'h7fff, 10'd0,    10'd1,    sender_gap());
    send_curve(CMD_CUB,    16'hffff, 16'h0001, 10'd1023, 10'd1023, sender_gap());
    send_curve(CMD_RSQR,   16'h7fff, 16'h7fff, 10'd1023, 10'd1023, sender_gap());

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) begin
        hold_req = 1'b1;
      end
      if (n == DRAIN_AT) begin
        s_tvalid <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end

      if ($urandom_range(0, 7) == 0) begin
        cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
      end else begin
        cmd = 3'($urandom_range(CMD_LIN, CMD_RCUB));
      end
      case ($urandom_range(0, 9))
        0: begin
          lo = 16'h8000;
        end
        1: begin
          lo = 16'h7fff;
        end
        default: begin
          lo = VAL_W'($urandom);
        end
      endcase
      case ($urandom_range(0, 9))
        0: begin
          hi = 16'h8000;
        end
        1: begin
          hi = 16'h7fff;
        end
        default: begin
          hi = VAL_W'($urandom);
        end
      endcase
      case ($urandom_range(0, 9))
        0: begin
          s = '0;
        end
        1, 2: begin
          s = POS_W'($urandom_range(1, 8));
        end
        default: begin
          s = POS_W'($urandom);
        end
      endcase
      if (s != '0 && $urandom_range(0, 3) != 0) begin
        x = POS_W'($urandom_range(0, s));
      end else begin
        x = POS_W'($urandom);
      end

      gap = (n >= HOLD_AT && n < HOLD_AT + HOLD_ITEMS) ? 0 : sender_gap();
      send_curve(cmd, lo, hi, x, s, gap);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
